// ===== rtl/drs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants for the dependency-ready scheduler
// Request and result codes, controller states, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int NODES_DEFAULT = 16;
    localparam int TASK_N        = 16;  // tasks addressable by index and mask
    localparam int TASK_W        = 4;
    localparam int CNT_W         = 5;
    localparam int REQ_W         = 2;
    localparam int KIND_W        = 2;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 16;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_BAD   = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DISPATCH = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ACK      = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // register index of node_count
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef struct packed {
        logic  mem_wr;      // store the dependency mask of the input item
        logic  clr_task;    // move the input task from active to cleared
        logic  scan_start;  // rewind the scan pointer, drop any pending task
        logic  scan_adv;    // step the scan pointer
        logic  pend_set;    // hold the task under the pointer and mark it active
        logic  pend_drop;
        logic  emit;        // load the output register
        kind_t emit_kind;
        logic  emit_last;
        logic  emit_pend;   // result carries the pending task index
    } drs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic clear_ok;
        logic clear_final;
        logic scan_end;
        logic task_ready;
        logic pend_valid;
    } drs_status_t;

endpackage
`default_nettype wire

// ===== rtl/drs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drs_ctrl: scheduler controller
// Decodes each request and sequences the scan over the task list.
// ----------------------------------------------------------------------------
module drs_ctrl import drs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire req_t        in_req,
    output logic             in_ready,
    input  wire drs_status_t st,
    output drs_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.mem_wr     = 1'b0;
        cmd.clr_task   = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan_adv   = 1'b0;
        cmd.pend_set   = 1'b0;
        cmd.pend_drop  = 1'b0;
        cmd.emit       = 1'b0;
        cmd.emit_kind  = KIND_ACK;
        cmd.emit_last  = 1'b0;
        cmd.emit_pend  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = st.out_free;
                if (in_valid && st.out_free) begin
                    case (in_req)
                        REQ_LOAD: begin
                            cmd.mem_wr    = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_ACK;
                            cmd.emit_last = 1'b1;
                        end
                        REQ_START: begin
                            if (st.cnt_zero) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = KIND_COMPLETE;
                                cmd.emit_last = 1'b1;
                            end else begin
                                cmd.scan_start = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            if (!st.clear_ok) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = KIND_ERROR;
                                cmd.emit_last = 1'b1;
                            end else begin
                                cmd.clr_task = 1'b1;
                                if (st.clear_final) begin
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = KIND_COMPLETE;
                                    cmd.emit_last = 1'b1;
                                end else begin
                                    cmd.scan_start = 1'b1;
                                    state_next     = ST_SCAN;
                                end
                            end
                        end
                        default: begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_ERROR;
                            cmd.emit_last = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (st.scan_end) begin
                    // flush the held dispatch as the final result, or acknowledge
                    if (st.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.emit_pend = st.pend_valid;
                        cmd.emit_kind = st.pend_valid ? KIND_DISPATCH : KIND_ACK;
                        cmd.pend_drop = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (st.task_ready) begin
                    if (!st.pend_valid) begin
                        cmd.pend_set = 1'b1;
                        cmd.scan_adv = 1'b1;
                    end else if (st.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_DISPATCH;
                        cmd.emit_pend = 1'b1;
                        cmd.pend_set  = 1'b1;
                        cmd.scan_adv  = 1'b1;
                    end
                end else begin
                    cmd.scan_adv = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/drs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drs_dp: scheduler datapath
// Dependency mask registers, active and cleared masks, scan pointer,
// pending dispatch, output register and the node_count register.
// ----------------------------------------------------------------------------
module drs_dp import drs_pkg::*; #(
    parameter int NODES = NODES_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [TASK_W-1:0]     in_task,
    input  wire logic [TASK_N-1:0]     in_dep,
    input  wire drs_cmd_t              cmd,
    output drs_status_t                st,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output kind_t                      out_kind,
    output logic [TASK_W-1:0]          out_task,
    output logic [CNT_W-1:0]           out_cleared,
    output logic [CNT_W-1:0]           out_total,
    output logic                       out_last,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata
);

    localparam int DEPTH = (NODES < TASK_N) ? NODES : TASK_N;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [TASK_N-1:0]  dep_reg [DEPTH];
    logic [TASK_N-1:0]  active_reg,  active_next;
    logic [TASK_N-1:0]  cleared_reg, cleared_next;
    logic [CNT_W-1:0]   cleared_cnt_reg, cleared_cnt_next;
    logic [CNT_W-1:0]   node_count_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic               pend_valid_reg;
    logic [TASK_W-1:0]  pend_task_reg;
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [TASK_W-1:0]  out_task_reg;
    logic [CNT_W-1:0]   out_cleared_reg;
    logic [CNT_W-1:0]   out_total_reg;
    logic               out_last_reg;

    logic [CNT_W-1:0]   eff_count;
    logic               cfg_wr;
    logic [TASK_W-1:0]  scan_task;
    logic [TASK_N-1:0]  scan_deps;

    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign eff_count = (node_count_reg > DEPTH_C) ? DEPTH_C : node_count_reg;
    assign prdata    = (paddr[2] == REG_NODE_COUNT) ?
                       APB_DATA_W'(node_count_reg) : '0;

    assign scan_task = scan_idx_reg[TASK_W-1:0];
    assign scan_deps = dep_reg[scan_idx_reg[IDX_W-1:0]];

    assign st.out_free    = !out_valid_reg || out_ready;
    assign st.cnt_zero    = (eff_count == '0);
    assign st.clear_ok    = ({1'b0, in_task} < eff_count) && active_reg[in_task];
    assign st.clear_final = ((cleared_cnt_reg + CNT_W'(1)) == eff_count);
    assign st.scan_end    = (scan_idx_reg == eff_count);
    assign st.task_ready  = !active_reg[scan_task] && !cleared_reg[scan_task]
                            && ((scan_deps & ~cleared_reg) == '0);
    assign st.pend_valid  = pend_valid_reg;

    // dependency masks: no reset, an entry is defined once loaded
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr && ({1'b0, in_task} < DEPTH_C)) begin
            dep_reg[in_task[IDX_W-1:0]] <= in_dep;
        end
    end

    always_comb begin
        active_next      = active_reg;
        cleared_next     = cleared_reg;
        cleared_cnt_next = cleared_cnt_reg;
        if (cmd.clr_task) begin
            active_next[in_task]  = 1'b0;
            cleared_next[in_task] = 1'b1;
            cleared_cnt_next      = cleared_cnt_reg + CNT_W'(1);
        end
        if (cmd.pend_set) begin
            active_next[scan_task] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= '0;
            active_reg      <= '0;
            cleared_reg     <= '0;
            cleared_cnt_reg <= '0;
        end else if (cfg_wr) begin
            node_count_reg  <= pwdata[CNT_W-1:0];
            active_reg      <= '0;
            cleared_reg     <= '0;
            cleared_cnt_reg <= '0;
        end else begin
            active_reg      <= active_next;
            cleared_reg     <= cleared_next;
            cleared_cnt_reg <= cleared_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_adv) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (cmd.scan_start || cmd.pend_drop) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.pend_set) begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_set) begin
            pend_task_reg <= scan_task;
        end
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg    <= cmd.emit_kind;
            out_task_reg    <= cmd.emit_pend ? pend_task_reg : '0;
            out_cleared_reg <= cleared_cnt_next;
            out_total_reg   <= eff_count;
            out_last_reg    <= cmd.emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_task    = out_task_reg;
    assign out_cleared = out_cleared_reg;
    assign out_total   = out_total_reg;
    assign out_last    = out_last_reg;

`ifndef SYNTH
    a_masks_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg & cleared_reg) == '0)
        else $error("task both active and cleared");

    a_cleared_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cleared_reg) == 32'(cleared_cnt_reg))
        else $error("cleared count out of step with cleared mask");

    a_pend_active: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> active_reg[pend_task_reg])
        else $error("held dispatch not marked active");
`endif

endmodule
`default_nettype wire

// ===== rtl/dependency_ready_scheduler_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dependency_ready_scheduler_top: dependency-ready task scheduler
// Holds a task graph, dispatches tasks whose dependencies are all cleared.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | request: tuser request type, tdata task index and mask
//  m_*      | out       | results: tuser kind, tdata task and counts, tlast
//  APB      | in/out    | node_count at byte address 0
//
//  Load, clear-with-error, complete and unknown requests are answered at
//  the accept. Start and a clear that rescans go through the accept, one
//  scan step per task up to count, and one to close; count is node_count
//  capped at NODES and at 16. The scan pointer steps one task a cycle and
//  halts where it must hand a dispatch to the output register while that
//  register holds an untaken transaction. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module dependency_ready_scheduler_top import drs_pkg::*; #(
    parameter int NODES = NODES_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // task_index[3:0], dep_mask[19:4]
    input  wire logic [REQ_W-1:0]      s_tuser,  // req_type[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,  // out_task[3:0], cleared_count[8:4],
                                                 // total_count[13:9]
    output logic [KIND_W-1:0]          m_tuser,  // result_kind[1:0]
    output logic                       m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    drs_cmd_t          cmd;
    drs_status_t       st;
    kind_t             out_kind;
    logic [TASK_W-1:0] out_task;
    logic [CNT_W-1:0]  out_cleared;
    logic [CNT_W-1:0]  out_total;

    assign pready = 1'b1;

    drs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_req   (req_t'(s_tuser)),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    drs_dp #(
        .NODES (NODES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_task     (s_tdata[3:0]),
        .in_dep      (s_tdata[19:4]),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_task    (out_task),
        .out_cleared (out_cleared),
        .out_total   (out_total),
        .out_last    (m_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {2'b00, out_total, out_cleared, out_task};

endmodule
`default_nettype wire

// ===== test/tb_dependency_ready_scheduler_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dependency_ready_scheduler_top: self-checking bench for the scheduler
// Walks a directed table, then runs random task graphs: load the masks,
// start, clear active tasks until complete or stuck, with noise between.
// Every accepted request runs through a scheduler predictor; results on the
// output stream are checked in order against the predicted or tabled ones.
// ----------------------------------------------------------------------------
module tb_dependency_ready_scheduler_top;
    import drs_pkg::*;

    localparam int NODES           = NODES_DEFAULT;
    localparam int RANDOM_ITEMS    = 430;
    localparam int QUIET_ITEMS     = 60;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int PLAN_ROWS       = 28;

    typedef struct packed {
        kind_t              kind;
        logic [TASK_W-1:0]  task_id;
        logic [CNT_W-1:0]   cleared;
        logic [CNT_W-1:0]   total;
        logic               last;
    } sched_result_t;

    typedef struct packed {
        logic               is_cfg;
        logic [CNT_W-1:0]   cfg_val;
        req_t               req;
        logic [TASK_W-1:0]  idx;
        logic [TASK_N-1:0]  mask;
        logic               typed;
        sched_result_t      exp_r;
    } plan_row_t;

    localparam sched_result_t NO_RESULT = '0;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // scheduler predictor state
    logic [TASK_N-1:0]     dep_table [TASK_N];
    logic [TASK_N-1:0]     active_q;
    logic [TASK_N-1:0]     cleared_q;
    logic [CNT_W-1:0]      node_count_q;

    sched_result_t         step_results[$];
    sched_result_t         awaited_results[$];
    plan_row_t             plan [PLAN_ROWS];

    int                    mismatches = 0;
    int                    stall_cycles = 0;
    bit                    quiet = 1'b0;
    bit                    hold_off_armed = 1'b0;

    always #6 aclk = ~aclk;

    dependency_ready_scheduler_top #(.NODES(NODES)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // task_index[3:0], dep_mask[19:4]
        .s_tuser  (s_tuser),   // req_type[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // out_task[3:0], cleared_count[8:4], total_count[13:9]
        .m_tuser  (m_tuser),   // result_kind[1:0]
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic logic [CNT_W-1:0] effective_count();
        int c;
        c = node_count_q;
        if (c > NODES) c = NODES;
        if (c > TASK_N) c = TASK_N;
        return CNT_W'(c);
    endfunction

    function automatic void push_result(kind_t kind, logic [TASK_W-1:0] id);
        sched_result_t r;
        r.kind    = kind;
        r.task_id = id;
        r.cleared = CNT_W'($countones(cleared_q));
        r.total   = effective_count();
        r.last    = 1'b0;
        step_results = {step_results, r};
    endfunction

    // Dispatch every ready task in index order; acknowledge if none is ready.
    function automatic void rescan_ready();
        int cnt;
        int found;
        cnt   = effective_count();
        found = 0;
        for (int i = 0; i < cnt; i++) begin
            if (active_q[i] || cleared_q[i]) continue;
            if ((dep_table[i] & ~cleared_q) != '0) continue;
            active_q[i] = 1'b1;
            push_result(KIND_DISPATCH, TASK_W'(i));
            found++;
        end
        if (found == 0) push_result(KIND_ACK, '0);
    endfunction

    function automatic void predict_request(req_t req, logic [TASK_W-1:0] idx,
                                            logic [TASK_N-1:0] mask);
        int cnt;
        cnt = effective_count();
        step_results.delete();
        case (req)
            REQ_LOAD: begin
                if (int'(idx) < NODES) dep_table[idx] = mask;
                push_result(KIND_ACK, '0);
            end
            REQ_START: begin
                if (cnt == 0) push_result(KIND_COMPLETE, '0);
                else rescan_ready();
            end
            REQ_CLEAR: begin
                if (int'(idx) >= cnt || !active_q[idx]) begin
                    push_result(KIND_ERROR, '0);
                end else begin
                    active_q[idx]  = 1'b0;
                    cleared_q[idx] = 1'b1;
                    if ($countones(cleared_q) == cnt) push_result(KIND_COMPLETE, '0);
                    else rescan_ready();
                end
            end
            default: push_result(KIND_ERROR, '0);
        endcase
        step_results[step_results.size()-1].last = 1'b1;
    endfunction

    function automatic string show_result(sched_result_t r);
        return $sformatf("kind %0d task %0d cleared %0d total %0d last %0b",
                         r.kind, r.task_id, r.cleared, r.total, r.last);
    endfunction

    // Drop valid, drain every awaited result, then let the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_NODE_COUNT, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_count_q = value;
        active_q     = '0;
        cleared_q    = '0;
    endtask

    task automatic issue_request(input req_t req, input logic [TASK_W-1:0] idx,
                                 input logic [TASK_N-1:0] mask, input bit typed,
                                 input sched_result_t typed_res);
        s_tuser  <= req;
        s_tdata  <= IN_DATA_W'({mask, idx});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(req, idx, mask);
        if (typed) awaited_results = {awaited_results, typed_res};
        else foreach (step_results[k]) awaited_results = {awaited_results, step_results[k]};
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    function automatic logic [TASK_W-1:0] pick_active();
        logic [TASK_W-1:0] i;
        i = TASK_W'($urandom_range(0, TASK_N - 1));
        while (!active_q[i]) i = i + 1'b1;
        return i;
    endfunction

    // Receiver: random back-pressure bursts, one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            if (hold_off_armed) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_armed = 1'b0;
            end else if (!quiet && aresetn && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind    = kind_t'(m_tuser);
            got.task_id = m_tdata[3:0];
            got.cleared = m_tdata[8:4];
            got.total   = m_tdata[13:9];
            got.last    = m_tlast;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %s", show_result(got));
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %s, got %s",
                                 show_result(want), show_result(got));
                end
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves anywhere.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int                random_items;
        int                n;
        int                r;
        bit                hold_off_done;
        logic [TASK_N-1:0] mask;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_LOAD;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        foreach (dep_table[i]) dep_table[i] = '0;
        active_q      = '0;
        cleared_q     = '0;
        node_count_q  = '0;
        random_items  = 0;
        hold_off_done = 1'b0;

        plan[0]  = '{1'b0, 5'd0,  REQ_START, 4'd0,  16'h0000, 1'b1,
                     '{KIND_COMPLETE, 4'd0, 5'd0, 5'd0, 1'b1}};
        plan[1]  = '{1'b0, 5'd0,  REQ_CLEAR, 4'd0,  16'h0000, 1'b1,
                     '{KIND_ERROR, 4'd0, 5'd0, 5'd0, 1'b1}};
        plan[2]  = '{1'b0, 5'd0,  REQ_BAD,   4'd15, 16'hFFFF, 1'b1,
                     '{KIND_ERROR, 4'd0, 5'd0, 5'd0, 1'b1}};
        plan[3]  = '{1'b0, 5'd0,  REQ_LOAD,  4'd0,  16'h0000, 1'b1,
                     '{KIND_ACK, 4'd0, 5'd0, 5'd0, 1'b1}};
        plan[4]  = '{1'b1, 5'd4,  REQ_LOAD,  4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[5]  = '{1'b0, 5'd0,  REQ_LOAD,  4'd1,  16'h0001, 1'b1,
                     '{KIND_ACK, 4'd0, 5'd0, 5'd4, 1'b1}};
        plan[6]  = '{1'b0, 5'd0,  REQ_LOAD,  4'd2,  16'h0003, 1'b0, NO_RESULT};
        // task 3 waits on task 4, which lies outside the graph
        plan[7]  = '{1'b0, 5'd0,  REQ_LOAD,  4'd3,  16'h0010, 1'b0, NO_RESULT};
        plan[8]  = '{1'b0, 5'd0,  REQ_START, 4'd9,  16'h0000, 1'b0, NO_RESULT};
        plan[9]  = '{1'b0, 5'd0,  REQ_START, 4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[10] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd1,  16'h0000, 1'b1,
                     '{KIND_ERROR, 4'd0, 5'd0, 5'd4, 1'b1}};
        plan[11] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd5,  16'h0000, 1'b1,
                     '{KIND_ERROR, 4'd0, 5'd0, 5'd4, 1'b1}};
        plan[12] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[13] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd1,  16'h0000, 1'b0, NO_RESULT};
        plan[14] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd2,  16'h0000, 1'b0, NO_RESULT};
        plan[15] = '{1'b1, 5'd16, REQ_LOAD,  4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[16] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd15, 16'h0000, 1'b1,
                     '{KIND_ERROR, 4'd0, 5'd0, 5'd16, 1'b1}};
        plan[17] = '{1'b0, 5'd0,  REQ_LOAD,  4'd15, 16'hFFFF, 1'b1,
                     '{KIND_ACK, 4'd0, 5'd0, 5'd16, 1'b1}};
        plan[18] = '{1'b0, 5'd0,  REQ_BAD,   4'd0,  16'h0000, 1'b1,
                     '{KIND_ERROR, 4'd0, 5'd0, 5'd16, 1'b1}};
        plan[19] = '{1'b1, 5'd1,  REQ_LOAD,  4'd0,  16'h0000, 1'b0, NO_RESULT};
        // a task that waits on itself never becomes ready
        plan[20] = '{1'b0, 5'd0,  REQ_LOAD,  4'd0,  16'h0001, 1'b0, NO_RESULT};
        plan[21] = '{1'b0, 5'd0,  REQ_START, 4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[22] = '{1'b1, 5'd2,  REQ_LOAD,  4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[23] = '{1'b0, 5'd0,  REQ_LOAD,  4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[24] = '{1'b0, 5'd0,  REQ_LOAD,  4'd1,  16'h0001, 1'b0, NO_RESULT};
        plan[25] = '{1'b0, 5'd0,  REQ_START, 4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[26] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd0,  16'h0000, 1'b0, NO_RESULT};
        plan[27] = '{1'b0, 5'd0,  REQ_CLEAR, 4'd1,  16'h0000, 1'b1,
                     '{KIND_COMPLETE, 4'd0, 5'd2, 5'd2, 1'b1}};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg)
                write_node_count(plan[k].cfg_val);
            else
                issue_request(plan[k].req, plan[k].idx, plan[k].mask,
                              plan[k].typed, plan[k].exp_r);
        end

        // fill every mask once so that no scan reads an unwritten entry
        write_node_count(CNT_W'($urandom_range(0, 16)));
        for (int i = 0; i < TASK_N; i++) begin
            issue_request(REQ_LOAD, TASK_W'(i), TASK_N'($urandom), 1'b0, NO_RESULT);
            random_items++;
        end

        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 23);
            if (r < 3) n = 16;
            else if (r < 5) n = 0;
            else n = $urandom_range(1, 6);
            if (!hold_off_done && random_items > 120) n = 16;
            write_node_count(CNT_W'(n));
            if (!hold_off_done && n == 16) begin
                hold_off_armed = 1'b1;
                hold_off_done  = 1'b1;
            end

            // mostly acyclic graphs: each task waits on lower indices, now and then on any task
            for (int i = 0; i < n; i++) begin
                mask = TASK_N'($urandom) & ((TASK_N'(1) << i) - TASK_N'(1));
                if ($urandom_range(0, 9) == 0)
                    mask = mask | (TASK_N'(1) << $urandom_range(0, TASK_N - 1));
                issue_request(REQ_LOAD, TASK_W'(i), mask, 1'b0, NO_RESULT);
                random_items++;
            end
            issue_request(REQ_START, TASK_W'($urandom), TASK_N'($urandom), 1'b0, NO_RESULT);
            random_items++;

            while (active_q != '0) begin
                r = $urandom_range(0, 11);
                case (r)
                    0: issue_request(REQ_CLEAR, TASK_W'($urandom), '0, 1'b0, NO_RESULT);
                    1: issue_request(REQ_BAD, TASK_W'($urandom), TASK_N'($urandom),
                                     1'b0, NO_RESULT);
                    2: issue_request(REQ_START, TASK_W'($urandom), '0, 1'b0, NO_RESULT);
                    3: issue_request(REQ_LOAD, TASK_W'($urandom), TASK_N'($urandom),
                                     1'b0, NO_RESULT);
                    default: issue_request(REQ_CLEAR, pick_active(), TASK_N'($urandom),
                                           1'b0, NO_RESULT);
                endcase
                random_items++;
                if (random_items >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            end

            // stray request after the graph is done or stuck
            if ($urandom_range(0, 2) == 0) begin
                issue_request($urandom_range(0, 1) ? REQ_CLEAR : REQ_START,
                              TASK_W'($urandom), '0, 1'b0, NO_RESULT);
                random_items++;
            end
            if (random_items >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        end

        settle();
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
